// ----- hdl/fqu_pkg.sv -----
// Package for the unique-key queue: field widths, status codes, entry type and control states.
package fqu_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 5;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FQU_IDLE,
    FQU_SCAN,
    FQU_FINISH
  } fqu_state_e;

  typedef struct packed {
    logic signed [KeyW-1:0]  key;
    logic signed [DataW-1:0] data;
  } entry_t;

endpackage

// ----- hdl/fqu_if.sv -----
// Request and response channel interfaces of the unique-key queue.
interface fqu_req_if;
  import fqu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [KeyW-1:0]  entry_key;
  logic signed [DataW-1:0] entry_data;

  modport source (output valid, mode, entry_key, entry_data, input ready);
  modport sink   (input valid, mode, entry_key, entry_data, output ready);
endinterface

interface fqu_rsp_if;
  import fqu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [KeyW-1:0]  out_key;
  logic signed [DataW-1:0] out_data;
  logic [CountW-1:0]       held_count;
  logic                    is_empty;

  modport source (output valid, status, out_key, out_data, held_count, is_empty, input ready);
  modport sink   (input valid, status, out_key, out_data, held_count, is_empty, output ready);
endinterface

// ----- hdl/fifo_queue_unique_keys.sv -----
// Top level of the unique-key queue: control sequencer, pointers and response register.
// A first-in first-out queue of DEPTH key/data pairs that refuses an enqueue whose key is
// already held (status 1) or that finds the queue full (status 2); a dequeue returns the
// oldest pair (status 3) or reports empty (status 4). One request transaction is worked at a
// time. The stored keys are read one per cycle through the single read port of the key
// memory, from the oldest onward, and the scan stops at the first match. An enqueue reads each
// pair held before it in the scan state, or fewer on a match, and loads the response register
// from the finish state. A dequeue does one memory read and loads the response register from
// the finish state once the output register is free. The next request is taken the
// cycle after the response register loads. The response sits in that output register, so a
// new request is taken while an earlier response waits; the next response is held back only
// while that register is still full. There is no clearing pass after reset.
module fifo_queue_unique_keys #(
  parameter int unsigned DEPTH = fqu_pkg::DefDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fqu_req_if.sink      in_i,
  fqu_rsp_if.source    out_o
);
  import fqu_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  fqu_state_e        state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   scan_addr_q, scan_addr_d;
  logic [CntW-1:0]   left_q, left_d;
  logic              pend_q, pend_d;
  status_e           st_q, st_d;
  entry_t            req_q;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  entry_t            out_entry_q;
  logic [CntW-1:0]   out_count_q;
  logic              out_load;

  logic              accept;
  logic              out_free;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  entry_t            rd_entry;
  logic              wr_en;
  logic [CntW-1:0]   count_new;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    next_idx = (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  fqu_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (tail_q),
    .wr_entry_i (req_q)
  );

  assign in_i.ready = (state_q == FQU_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    scan_addr_d = scan_addr_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    st_d        = st_q;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    count_new   = count_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      FQU_IDLE: begin
        if (accept) begin
          if (in_i.mode) begin
            if (count_q == '0) begin
              st_d = ST_EMPTY;
            end else begin
              st_d  = ST_DEQUEUED;
              rd_en = 1'b1;
            end
            state_d = FQU_FINISH;
          end else begin
            scan_addr_d = head_q;
            left_d      = count_q;
            state_d     = FQU_SCAN;
          end
        end
      end
      FQU_SCAN: begin
        if (pend_q && (rd_entry.key == req_q.key)) begin
          st_d    = ST_DUPLICATE;
          state_d = FQU_FINISH;
        end else if (left_q == '0) begin
          st_d    = (count_q == FullCnt) ? ST_FULL : ST_ENQUEUED;
          state_d = FQU_FINISH;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = scan_addr_q;
          scan_addr_d = next_idx(scan_addr_q);
          left_d      = left_q - 1'b1;
          pend_d      = 1'b1;
        end
      end
      FQU_FINISH: begin
        case (st_q)
          ST_ENQUEUED: count_new = count_q + 1'b1;
          ST_DEQUEUED: count_new = count_q - 1'b1;
          default:     count_new = count_q;
        endcase
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          count_d     = count_new;
          state_d     = FQU_IDLE;
          if (st_q == ST_ENQUEUED) begin
            wr_en  = 1'b1;
            tail_d = next_idx(tail_q);
          end
          if (st_q == ST_DEQUEUED) begin
            head_d = next_idx(head_q);
          end
        end
      end
      default: state_d = FQU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FQU_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_addr_q <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      st_q        <= ST_ENQUEUED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      scan_addr_q <= scan_addr_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.key  <= in_i.entry_key;
      req_q.data <= in_i.entry_data;
    end
    if (out_load) begin
      out_status_q <= st_q;
      out_count_q  <= count_new;
      if (st_q == ST_DEQUEUED) begin
        out_entry_q <= rd_entry;
      end else begin
        out_entry_q <= '0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.out_key    = out_entry_q.key;
  assign out_o.out_data   = out_entry_q.data;
  assign out_o.held_count = CountW'(out_count_q);
  assign out_o.is_empty   = (out_count_q == '0);

endmodule

// ----- hdl/fqu_store.sv -----
// Entry storage of the queue: key and data memories, one write and one registered read port.
module fqu_store #(
  parameter int unsigned DEPTH = fqu_pkg::DefDepth
) (
  input  logic                                     clk_i,
  input  logic                                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]                 rd_addr_i,
  output fqu_pkg::entry_t                          rd_entry_o,
  input  logic                                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]                 wr_addr_i,
  input  fqu_pkg::entry_t                          wr_entry_i
);
  import fqu_pkg::*;

  logic signed [KeyW-1:0]  key_mem  [DEPTH];
  logic signed [DataW-1:0] data_mem [DEPTH];
  entry_t                  rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]  <= wr_entry_i.key;
      data_mem[wr_addr_i] <= wr_entry_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q.key  <= key_mem[rd_addr_i];
      rd_entry_q.data <= data_mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the unique-key queue: random and directed transactions.
module testbench;
  import fqu_pkg::*;

  localparam int unsigned QueueDepth  = DefDepth;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned KeyPoolSize = 24;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned DrainEvery  = 300;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [KeyW-1:0]  key;
    logic signed [DataW-1:0] data;
    logic                    drain;
  } request_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [KeyW-1:0]  key;
    logic signed [DataW-1:0] data;
    logic [CountW-1:0]       count;
    logic                    empty;
  } queue_result_t;

  logic clk;
  logic rst_n;

  fqu_req_if req_if ();
  fqu_rsp_if rsp_if ();

  fifo_queue_unique_keys #(
    .DEPTH(QueueDepth)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  request_item_t stimulus_items[$];
  queue_result_t pending_results[$];
  entry_t        held_pairs[$];
  logic signed [KeyW-1:0] key_pool[KeyPoolSize];

  int  total_items;
  int  sent_count;
  int  accepted_count;
  int  error_count;
  int  idle_cycles;
  logic req_taken;
  request_item_t next_item;

  always #5 clk = ~clk;

  // Shadow of the queue contents; returns the result a request must produce.
  function automatic queue_result_t queue_outcome(input request_item_t r);
    queue_result_t res;
    entry_t        pair;
    logic          dup;
    dup = 1'b0;
    res.key  = '0;
    res.data = '0;
    if (r.mode == MODE_ENQUEUE) begin
      foreach (held_pairs[i]) begin
        if (held_pairs[i].key == r.key) dup = 1'b1;
      end
      if (dup) begin
        res.status = ST_DUPLICATE;
      end else if (held_pairs.size() >= QueueDepth) begin
        res.status = ST_FULL;
      end else begin
        pair.key  = r.key;
        pair.data = r.data;
        held_pairs.push_back(pair);
        res.status = ST_ENQUEUED;
      end
    end else begin
      if (held_pairs.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        pair = held_pairs.pop_front();
        res.key    = pair.key;
        res.data   = pair.data;
        res.status = ST_DEQUEUED;
      end
    end
    res.count = CountW'(held_pairs.size());
    res.empty = (held_pairs.size() == 0);
    return res;
  endfunction

  task automatic check_result(input queue_result_t exp);
    if (rsp_if.status !== exp.status) begin
      $display("%0t: status expected %0d, got %0d", $time, exp.status, rsp_if.status);
      error_count++;
    end
    if (rsp_if.out_key !== exp.key) begin
      $display("%0t: out_key expected %0d, got %0d", $time, exp.key, rsp_if.out_key);
      error_count++;
    end
    if (rsp_if.out_data !== exp.data) begin
      $display("%0t: out_data expected %0d, got %0d", $time, exp.data, rsp_if.out_data);
      error_count++;
    end
    if (rsp_if.held_count !== exp.count) begin
      $display("%0t: held_count expected %0d, got %0d", $time, exp.count,
               rsp_if.held_count);
      error_count++;
    end
    if (rsp_if.is_empty !== exp.empty) begin
      $display("%0t: is_empty expected %0d, got %0d", $time, exp.empty, rsp_if.is_empty);
      error_count++;
    end
  endtask

  task automatic add_item(input logic mode, input logic signed [KeyW-1:0] key,
                          input logic signed [DataW-1:0] data, input logic drain);
    request_item_t it;
    it.mode  = mode;
    it.key   = key;
    it.data  = data;
    it.drain = drain;
    stimulus_items.push_back(it);
  endtask

  // Monitor, predictor and watchdog.
  always @(posedge clk) begin
    queue_result_t exp;
    logic          rsp_taken;
    if (rst_n) begin
      req_taken = req_if.valid && req_if.ready;
      rsp_taken = rsp_if.valid && rsp_if.ready;
      if (req_taken) begin
        next_item.mode = req_if.mode;
        next_item.key  = req_if.entry_key;
        next_item.data = req_if.entry_data;
        next_item.drain = 1'b0;
        pending_results.push_back(queue_outcome(next_item));
        accepted_count++;
      end
      if (rsp_taken) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected response, status %0d key %0d data %0d", $time,
                   rsp_if.status, rsp_if.out_key, rsp_if.out_data);
          error_count++;
        end else begin
          exp = pending_results.pop_front();
          check_result(exp);
        end
      end
      if (req_taken || rsp_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("FAILED: results differ");
        $finish;
      end
    end else begin
      req_taken = 1'b0;
    end
  end

  // Driver and response backpressure.
  always @(negedge clk) begin
    request_item_t it;
    int            gap_pct;
    int            stall_pct;
    if (rst_n) begin
      case (sent_count * 3 / total_items)
        0:       begin gap_pct = 11; stall_pct = 47; end
        1:       begin gap_pct = 47; stall_pct = 11; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      if (req_if.valid && !req_taken) begin
        // hold the offered transaction
      end else if (stimulus_items.size() != 0 &&
                   !(stimulus_items[0].drain && pending_results.size() != 0) &&
                   $urandom_range(99) >= gap_pct) begin
        it = stimulus_items.pop_front();
        req_if.valid      <= 1'b1;
        req_if.mode       <= it.mode;
        req_if.entry_key  <= it.key;
        req_if.entry_data <= it.data;
        sent_count++;
      end else begin
        req_if.valid <= 1'b0;
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    logic signed [KeyW-1:0] key;
    logic                   mode;
    int                     enq_pct;
    int                     burst_len;
    int                     n;

    clk               = 1'b0;
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_ENQUEUE;
    req_if.entry_key  = '0;
    req_if.entry_data = '0;
    rsp_if.ready      = 1'b0;
    req_taken         = 1'b0;
    sent_count        = 0;
    accepted_count    = 0;
    error_count       = 0;
    idle_cycles       = 0;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < KeyPoolSize; i++) key_pool[i] = $urandom;

    // Directed: empty dequeue, extremes, duplicate, fill, full, duplicate while full, wrap.
    add_item(MODE_DEQUEUE, '0, '0, 1'b0);
    add_item(MODE_ENQUEUE, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    add_item(MODE_ENQUEUE, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    add_item(MODE_ENQUEUE, -32'sd1, '0, 1'b0);
    add_item(MODE_ENQUEUE, '0, -32'sd1, 1'b0);
    add_item(MODE_ENQUEUE, 32'sh8000_0000, 32'sd5, 1'b0);
    for (int i = 1; i <= 12; i++) add_item(MODE_ENQUEUE, i, $urandom, 1'b0);
    add_item(MODE_ENQUEUE, 32'sd100, 32'sd7, 1'b0);
    add_item(MODE_ENQUEUE, 32'sh7fff_ffff, 32'sd9, 1'b0);
    add_item(MODE_DEQUEUE, $urandom, $urandom, 1'b0);
    add_item(MODE_ENQUEUE, 32'sh8000_0000, 32'sh1234_5678, 1'b0);
    add_item(MODE_DEQUEUE, $urandom, $urandom, 1'b0);
    add_item(MODE_DEQUEUE, $urandom, $urandom, 1'b0);

    // Random bursts biased toward filling, mixing or draining.
    n = 0;
    while (n < RandomItems) begin
      burst_len = $urandom_range(60, 10);
      case ($urandom_range(2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      for (int i = 0; i < burst_len && n < RandomItems; i++) begin
        mode = ($urandom_range(99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
        if ($urandom_range(99) < 70) key = key_pool[$urandom_range(KeyPoolSize - 1)];
        else key = $urandom;
        add_item(mode, key, $urandom, (n % DrainEvery) == DrainEvery - 1);
        n++;
      end
    end
    total_items = stimulus_items.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    @(negedge clk);
    while (accepted_count != total_items || pending_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- fifo_queue_unique_keys.f -----
hdl/fqu_pkg.sv
hdl/fqu_if.sv
hdl/fqu_store.sv
hdl/fifo_queue_unique_keys.sv
bench/testbench.sv
